[hdl/bb_pkg.sv]
// Shared types and constants for the 3x3 box filter.
// Used by every module of the block; depends on nothing.
`default_nettype none
package bb_pkg;

  localparam int CH_BITS = 8;
  localparam int MAX_CH = 3;
  localparam int PIX_BITS = CH_BITS * MAX_CH;
  localparam int FW_BITS = 12;
  localparam int FH_BITS = 13;
  localparam int ROW_BITS = 12;
  localparam int MAX_HEIGHT = 4096;
  localparam int CFG_BITS = 13;

  localparam logic [FW_BITS-1:0] FRAME_WIDTH_RST = 12'd640;
  localparam logic [FH_BITS-1:0] FRAME_HEIGHT_RST = 13'd480;

  localparam logic REG_FRAME_WIDTH = 1'b0;
  localparam logic REG_FRAME_HEIGHT = 1'b1;

  localparam logic CMD_PIXEL = 1'b0;
  localparam logic CMD_FLUSH = 1'b1;

  // floor(x * 7282 / 2^16) equals floor(x / 9) for sums of nine 8-bit values
  localparam int SUM_BITS = 12;
  localparam int RECIP_BITS = 13;
  localparam logic [RECIP_BITS-1:0] RECIP_NINE = 13'd7282;
  localparam int RECIP_SHIFT = 16;

  localparam int FIFO_DEPTH = 8;
  localparam int FIFO_AW = 3;
  localparam int FIFO_CW = 4;

  typedef struct packed {
    logic                command;
    logic [CH_BITS-1:0]  blue_in;
    logic [CH_BITS-1:0]  green_in;
    logic [CH_BITS-1:0]  red_in;
  } item_t;

  typedef struct packed {
    logic [CH_BITS-1:0]  blue_out;
    logic [CH_BITS-1:0]  green_out;
    logic [CH_BITS-1:0]  red_out;
    logic                end_of_frame;
    logic                last_of_run;
  } result_t;

endpackage
`default_nettype wire

[hdl/bb_line_buf.sv]
// Two line buffers (previous row and the row before it) with registered reads.
// Forwards an older-row write to a read of the same column issued in the same cycle.
// Depends on bb_pkg.
`default_nettype none
module bb_line_buf
  import bb_pkg::*;
#(
  parameter int DEPTH = 2048,
  parameter int DW = 24
) (
  input  wire logic                     clk,
  input  wire logic                     rst,
  input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
  input  wire logic                     newer_we,
  input  wire logic [DW-1:0]            newer_wd,
  input  wire logic                     older_we,
  input  wire logic [$clog2(DEPTH)-1:0] older_waddr,
  input  wire logic [DW-1:0]            older_wd,
  output logic      [DW-1:0]            older_q,
  output logic      [DW-1:0]            newer_q
);

  logic [DW-1:0] older_mem [DEPTH];
  logic [DW-1:0] newer_mem [DEPTH];
  logic [DW-1:0] older_rd;
  logic [DW-1:0] fwd_data;
  logic          fwd;

  always_ff @(posedge clk) begin
    older_rd <= older_mem[rd_addr];
    newer_q  <= newer_mem[rd_addr];
    if (newer_we) begin
      newer_mem[rd_addr] <= newer_wd;
    end
    if (older_we) begin
      older_mem[older_waddr] <= older_wd;
    end
    fwd_data <= older_wd;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      fwd <= 1'b0;
    end else begin
      fwd <= older_we && (older_waddr == rd_addr);
    end
  end

  assign older_q = fwd ? fwd_data : older_rd;

endmodule
`default_nettype wire

[hdl/bb_lane.sv]
// One color channel: 3x3 window, nine-value sum and mean by reciprocal.
// Depends on bb_pkg.
`default_nettype none
module bb_lane
  import bb_pkg::*;
(
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               shift,
  input  wire logic [CH_BITS-1:0] cur0,
  input  wire logic [CH_BITS-1:0] cur1,
  input  wire logic [CH_BITS-1:0] cur2,
  output logic      [CH_BITS-1:0] mean,
  output logic      [CH_BITS-1:0] pass
);

  logic [CH_BITS-1:0] win [3][2];
  logic [SUM_BITS-1:0] row_sum [3];
  logic [SUM_BITS-1:0] sum;
  logic [SUM_BITS-1:0] sum_q;
  logic [SUM_BITS+RECIP_BITS-1:0] prod;

  always_comb begin
    row_sum[0] = SUM_BITS'(win[0][0]) + SUM_BITS'(win[0][1]) + SUM_BITS'(cur0);
    row_sum[1] = SUM_BITS'(win[1][0]) + SUM_BITS'(win[1][1]) + SUM_BITS'(cur1);
    row_sum[2] = SUM_BITS'(win[2][0]) + SUM_BITS'(win[2][1]) + SUM_BITS'(cur2);
    sum = row_sum[0] + row_sum[1] + row_sum[2];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int r = 0; r < 3; r++) begin
        win[r][0] <= '0;
        win[r][1] <= '0;
      end
    end else if (shift) begin
      win[0][1] <= win[0][0];
      win[1][1] <= win[1][0];
      win[2][1] <= win[2][0];
      win[0][0] <= cur0;
      win[1][0] <= cur1;
      win[2][0] <= cur2;
    end
  end

  always_ff @(posedge clk) begin
    sum_q <= sum;
    pass  <= win[1][0];
  end

  assign prod = (SUM_BITS+RECIP_BITS)'(sum_q) * (SUM_BITS+RECIP_BITS)'(RECIP_NINE);
  assign mean = prod[RECIP_SHIFT +: CH_BITS];

endmodule
`default_nettype wire

[hdl/box_blur_3x3_top.sv]
// 3x3 box filter top level: position control, line buffers, channel lanes,
// result merge and output queue. Depends on bb_pkg, bb_line_buf, bb_lane.
//
// Usage:
//   item channel (item_valid/item_ready/item): pixels in raster order with
//   command = pixel, then flush commands, one per pixel of the final row.
//   result channel (result_valid/result_ready/result): the frame in raster
//   order, one row and one pixel behind the input; interior pixels carry the
//   truncated 3x3 mean per channel, border pixels pass through unchanged.
//   cfg channel (cfg_valid/cfg_ready/cfg_index/cfg_data): frame_width at
//   index 0, frame_height at index 1; always ready, write only while idle.
// Timing: one item per cycle while item_ready is high. A pixel yields 0, 1
//   or 2 results (two at the end of a row after the first), a flush yields 1.
//   An item's first result passes the stage 1 and stage 2 registers and is
//   written to the output queue before it is valid. The queue holds 8 results;
//   item_ready drops when the queue cannot take the results of the items in
//   flight plus one more item, so a stalled receiver stops input and nothing is lost.
// Reset: positions, window and queue clear, frame size returns to 640x480.
//   Line buffers are not cleared.
`default_nettype none
module box_blur_3x3_top
  import bb_pkg::*;
#(
  parameter int MAX_WIDTH = 2048,
  parameter int CHANNELS = 3
) (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic                item_valid,
  output logic                     item_ready,
  input  wire item_t               item,
  output logic                     result_valid,
  input  wire logic                result_ready,
  output result_t                  result,
  input  wire logic                cfg_valid,
  output logic                     cfg_ready,
  input  wire logic                cfg_index,
  input  wire logic [CFG_BITS-1:0] cfg_data
);

  localparam int CW = $clog2(MAX_WIDTH);
  localparam int LANES = (CHANNELS < MAX_CH) ? CHANNELS : MAX_CH;
  localparam int LW = LANES * CH_BITS;

  function automatic result_t make_result(logic [LW-1:0] px, logic eof, logic last);
    logic [PIX_BITS-1:0] wide;
    result_t res;
    wide = PIX_BITS'(px);
    res.blue_out = wide[0 +: CH_BITS];
    res.green_out = wide[CH_BITS +: CH_BITS];
    res.red_out = wide[2*CH_BITS +: CH_BITS];
    res.end_of_frame = eof;
    res.last_of_run = last;
    return res;
  endfunction

  logic [FW_BITS-1:0] frame_width;
  logic [FH_BITS-1:0] frame_height;
  logic [CW-1:0]       last_col;
  logic [ROW_BITS-1:0] last_row;

  logic [CW-1:0]       col_pos;
  logic [ROW_BITS-1:0] row_pos;
  logic [CW-1:0]       flush_pos;
  logic                flush_pending;

  logic [CW-1:0]       c;
  logic [ROW_BITS-1:0] r;
  logic [CW-1:0]       f;
  logic                accept;
  logic                take_pix;
  logic                take_flush;
  logic [CW-1:0]       rd_addr;
  logic [PIX_BITS-1:0] in_wide;
  logic [LW-1:0]       in_px;
  logic                emit1;
  logic                emit2;
  logic [1:0]          n0;

  logic                s1_pix;
  logic                s1_flush;
  logic [1:0]          s1_n;
  logic [CW-1:0]       s1_addr;
  logic [LW-1:0]       s1_px;
  logic                s1_emit1;
  logic                s1_interior;
  logic                s1_emit2;
  logic                s1_eof;

  logic                s2_pix;
  logic                s2_flush;
  logic [1:0]          s2_n;
  logic [LW-1:0]       s2_cur1;
  logic                s2_emit1;
  logic                s2_interior;
  logic                s2_emit2;
  logic                s2_eof;

  logic [LW-1:0]       older_q;
  logic [LW-1:0]       newer_q;
  logic [LW-1:0]       mean_vec;
  logic [LW-1:0]       pass_vec;

  result_t             fifo [FIFO_DEPTH];
  logic [FIFO_AW-1:0]  wr_ptr;
  logic [FIFO_AW-1:0]  rd_ptr;
  logic [FIFO_CW-1:0]  count;
  logic                pop;
  result_t             res_main;
  result_t             res_tail;
  result_t             res_first;

  // configuration
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      frame_width  <= FRAME_WIDTH_RST;
      frame_height <= FRAME_HEIGHT_RST;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        REG_FRAME_WIDTH: begin
          frame_width <= cfg_data[FW_BITS-1:0];
        end
        REG_FRAME_HEIGHT: begin
          frame_height <= cfg_data[FH_BITS-1:0];
        end
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    priority if (frame_width == '0) begin
      last_col = '0;
    end else if (32'(frame_width) > MAX_WIDTH) begin
      last_col = CW'(MAX_WIDTH - 1);
    end else begin
      last_col = CW'(frame_width - FW_BITS'(1));
    end
    priority if (frame_height == '0) begin
      last_row = '0;
    end else if (32'(frame_height) > MAX_HEIGHT) begin
      last_row = ROW_BITS'(MAX_HEIGHT - 1);
    end else begin
      last_row = ROW_BITS'(frame_height - FH_BITS'(1));
    end
  end

  // stage 0: positions, line buffer read
  assign c = (col_pos > last_col) ? last_col : col_pos;
  assign r = (row_pos > last_row) ? last_row : row_pos;
  assign f = (flush_pos > last_col) ? last_col : flush_pos;

  assign accept = item_valid && item_ready;
  assign take_pix = accept && (item.command == CMD_PIXEL) && !flush_pending;
  assign take_flush = accept && (item.command == CMD_FLUSH) && flush_pending;
  assign rd_addr = (item.command == CMD_FLUSH) ? f : c;
  assign in_wide = {item.red_in, item.green_in, item.blue_in};
  assign in_px = in_wide[LW-1:0];
  assign emit1 = (r != '0) && (c != '0);
  assign emit2 = (r != '0) && (c == last_col);
  assign n0 = take_pix ? (2'(emit1) + 2'(emit2)) : 2'(take_flush);

  always_ff @(posedge clk) begin
    if (rst) begin
      col_pos       <= '0;
      row_pos       <= '0;
      flush_pos     <= '0;
      flush_pending <= 1'b0;
    end else if (take_pix) begin
      if (c == last_col) begin
        col_pos <= '0;
        if (r == last_row) begin
          row_pos       <= '0;
          flush_pending <= 1'b1;
          flush_pos     <= '0;
        end else begin
          row_pos <= r + ROW_BITS'(1);
        end
      end else begin
        col_pos <= c + CW'(1);
      end
    end else if (take_flush) begin
      if (f == last_col) begin
        flush_pending <= 1'b0;
        flush_pos     <= '0;
      end else begin
        flush_pos <= f + CW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_pix   <= 1'b0;
      s1_flush <= 1'b0;
      s1_n     <= '0;
      s2_pix   <= 1'b0;
      s2_flush <= 1'b0;
      s2_n     <= '0;
    end else begin
      s1_pix   <= take_pix;
      s1_flush <= take_flush;
      s1_n     <= n0;
      s2_pix   <= s1_pix;
      s2_flush <= s1_flush;
      s2_n     <= s1_n;
    end
  end

  always_ff @(posedge clk) begin
    s1_addr     <= rd_addr;
    s1_px       <= in_px;
    s1_emit1    <= emit1;
    s1_interior <= (r >= ROW_BITS'(2)) && (c >= CW'(2));
    s1_emit2    <= emit2;
    s1_eof      <= (f == last_col);
    s2_cur1     <= newer_q;
    s2_emit1    <= s1_emit1;
    s2_interior <= s1_interior;
    s2_emit2    <= s1_emit2;
    s2_eof      <= s1_eof;
  end

  bb_line_buf #(
    .DEPTH (MAX_WIDTH),
    .DW    (LW)
  ) u_line_buf (
    .clk         (clk),
    .rst         (rst),
    .rd_addr     (rd_addr),
    .newer_we    (take_pix),
    .newer_wd    (in_px),
    .older_we    (s1_pix),
    .older_waddr (s1_addr),
    .older_wd    (newer_q),
    .older_q     (older_q),
    .newer_q     (newer_q)
  );

  // stage 1: one lane per channel
  for (genvar k = 0; k < LANES; k++) begin : g_lane
    bb_lane u_lane (
      .clk   (clk),
      .rst   (rst),
      .shift (s1_pix),
      .cur0  (older_q[k*CH_BITS +: CH_BITS]),
      .cur1  (newer_q[k*CH_BITS +: CH_BITS]),
      .cur2  (s1_px[k*CH_BITS +: CH_BITS]),
      .mean  (mean_vec[k*CH_BITS +: CH_BITS]),
      .pass  (pass_vec[k*CH_BITS +: CH_BITS])
    );
  end

  // stage 2: merge lanes into results and queue them
  always_comb begin
    res_main = make_result(s2_interior ? mean_vec : pass_vec, 1'b0, !s2_emit2);
    res_tail = make_result(s2_cur1, s2_flush && s2_eof, 1'b1);
    res_first = (s2_pix && s2_emit1) ? res_main : res_tail;
  end

  assign result_valid = (count != '0);
  assign result = fifo[rd_ptr];
  assign pop = result_valid && result_ready;
  assign item_ready = (5'(count) + 5'(s1_n) + 5'(s2_n)) <= 5'(FIFO_DEPTH - 2);

  always_ff @(posedge clk) begin
    if (s2_n != '0) begin
      fifo[wr_ptr] <= res_first;
    end
    if (s2_n == 2'd2) begin
      fifo[wr_ptr + FIFO_AW'(1)] <= res_tail;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      wr_ptr <= wr_ptr + FIFO_AW'(s2_n);
      if (pop) begin
        rd_ptr <= rd_ptr + FIFO_AW'(1);
      end
      count <= count + FIFO_CW'(s2_n) - FIFO_CW'(pop);
    end
  end

endmodule
`default_nettype wire
